>>> hw/rtl/roulette_wheel_select_core_assert.svh
// Assertion macros for the roulette wheel select core.
`ifndef ROULETTE_WHEEL_SELECT_CORE_ASSERT_SVH
`define ROULETTE_WHEEL_SELECT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RWS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel select core.
package rws_pkg;

   localparam int KIND_W              = 2;
   localparam int WEIGHT_W            = 32;
   localparam int FRAC_W              = 16;
   localparam int INDEX_W             = 8;
   localparam int PROD_W              = WEIGHT_W + FRAC_W;
   localparam int MAX_ENTRIES_DEFAULT = 256;

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SELECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_MUL,
      ST_FETCH,
      ST_CMP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic append;
      logic clear;
      logic start_search;
      logic read_total;
      logic load_prod;
      logic go_left;
      logic go_right;
      logic finish_lo;
      logic finish_mid;
      logic finish_err;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;
      logic search_done;
      logic below_a;
      logic below_b;
   } status_type;

endpackage

>>> hw/rtl/rws_ctrl.sv
// Controller state machine for the roulette wheel select core.
module rws_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rws_pkg::KIND_W-1:0]      req_kind,
   input  rws_pkg::status_type             status,
   output rws_pkg::cmd_type                cmd,
   output logic                            busy
);

   rws_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rws_pkg::ST_IDLE: begin
            if (start && req_kind == rws_pkg::KIND_SELECT && !status.count_zero) begin
               state_in = rws_pkg::ST_TOTAL;
            end
         end
         rws_pkg::ST_TOTAL: state_in = rws_pkg::ST_MUL;
         rws_pkg::ST_MUL:   state_in = rws_pkg::ST_FETCH;
         rws_pkg::ST_FETCH: begin
            state_in = status.search_done ? rws_pkg::ST_IDLE : rws_pkg::ST_CMP;
         end
         rws_pkg::ST_CMP: begin
            if (status.below_a || !status.below_b) begin
               state_in = rws_pkg::ST_FETCH;
            end else begin
               state_in = rws_pkg::ST_IDLE;
            end
         end
         default: state_in = rws_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         rws_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_kind)
                  rws_pkg::KIND_APPEND: cmd.append = 1'b1;
                  rws_pkg::KIND_CLEAR:  cmd.clear  = 1'b1;
                  rws_pkg::KIND_SELECT: begin
                     cmd.finish_err   = status.count_zero;
                     cmd.start_search = !status.count_zero;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         rws_pkg::ST_TOTAL: cmd.read_total = 1'b1;
         rws_pkg::ST_MUL:   cmd.load_prod  = 1'b1;
         rws_pkg::ST_FETCH: cmd.finish_lo  = status.search_done;
         rws_pkg::ST_CMP: begin
            if (status.below_a) begin
               cmd.go_left = 1'b1;
            end else if (!status.below_b) begin
               cmd.go_right = 1'b1;
            end else begin
               cmd.finish_mid = 1'b1;
            end
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

>>> hw/rtl/rws_dp.sv
// Datapath of the roulette wheel select core: prefix table, search bounds, product.
module rws_dp #(
   parameter int MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rws_pkg::cmd_type              cmd,
   input  logic [rws_pkg::WEIGHT_W-1:0]  req_cumulative_weight,
   input  logic [rws_pkg::FRAC_W-1:0]    req_random_fraction,
   output rws_pkg::status_type           status,
   output logic                          rsp_valid,
   output logic [rws_pkg::INDEX_W-1:0]   rsp_chosen_index,
   output logic                          rsp_empty_error
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [rws_pkg::WEIGHT_W-1:0] mem [MAX_ENTRIES];

   logic [CNT_W-1:0]             count_ff, count_in;
   // bounds are count wide: the lower one may run one past the last entry
   logic [CNT_W-1:0]             lo_ff, lo_in, hi_ff, hi_in;
   logic [rws_pkg::FRAC_W-1:0]   frac_ff;
   logic [rws_pkg::PROD_W-1:0]   prod_ff;
   logic [rws_pkg::WEIGHT_W-1:0] rd_a_ff, rd_b_ff;
   logic                         valid_ff, valid_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic                         err_ff, err_in;

   logic [CNT_W:0]               mid_sum;
   logic [CNT_W-1:0]             mid, mid_dec;
   logic [IDX_W-1:0]             addr_a, addr_b;
   logic                         search_done;
   logic                         table_full;
   logic [rws_pkg::PROD_W-1:0]   product;
   logic [CNT_W+rws_pkg::INDEX_W-1:0] idx_wide;

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign mid         = mid_sum[CNT_W:1];
   assign mid_dec     = mid - {{(CNT_W-1){1'b0}}, 1'b1};
   assign search_done = (lo_ff >= hi_ff);
   assign table_full  = (count_ff >= CNT_W'(MAX_ENTRIES));

   // lower port reads entry mid-1, upper port entry mid (or the last entry for the total)
   assign addr_a = search_done ? '0 : mid_dec[IDX_W-1:0];
   assign addr_b = cmd.read_total ? hi_ff[IDX_W-1:0] : mid[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.append && !table_full) begin
         mem[count_ff[IDX_W-1:0]] <= req_cumulative_weight;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // 16 x 32 product of the draw and the total
   assign product = {{rws_pkg::WEIGHT_W{1'b0}}, frac_ff}
                  * {{rws_pkg::FRAC_W{1'b0}}, rd_b_ff};

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && !table_full) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start_search) begin
         lo_in = '0;
         hi_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (cmd.go_left) begin
         hi_in = mid_dec;
      end else if (cmd.go_right) begin
         lo_in = mid + {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      valid_in = cmd.finish_lo || cmd.finish_mid || cmd.finish_err;
      err_in   = cmd.finish_err;
      idx_in   = idx_ff;
      if (cmd.finish_err) begin
         idx_in = '0;
      end else if (cmd.finish_lo) begin
         idx_in = lo_ff;
      end else if (cmd.finish_mid) begin
         idx_in = mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
      err_ff <= err_in;
      if (cmd.start_search) begin
         frac_ff <= req_random_fraction;
      end
      if (cmd.load_prod) begin
         prod_ff <= product;
      end
   end

   assign status.count_zero  = (count_ff == '0);
   assign status.search_done = search_done;
   assign status.below_a     = prod_ff < {rd_a_ff, {rws_pkg::FRAC_W{1'b0}}};
   assign status.below_b     = prod_ff < {rd_b_ff, {rws_pkg::FRAC_W{1'b0}}};

   // index is reported modulo 256
   assign idx_wide         = {{rws_pkg::INDEX_W{1'b0}}, idx_ff};
   assign rsp_valid        = valid_ff;
   assign rsp_chosen_index = idx_wide[rws_pkg::INDEX_W-1:0];
   assign rsp_empty_error  = err_ff;

endmodule

>>> hw/rtl/roulette_wheel_select_core.sv
// Top level of the roulette wheel select core: controller plus datapath.
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  ------------------------
//  request   req_kind, req_cumulative_weight,               start && !busy
//            req_random_fraction
//  response  rsp_chosen_index, rsp_empty_error              rsp_valid, one cycle
//
// Append and clear items finish in the cycle they are accepted; busy stays low.
// A select on an empty table answers in the next cycle with the error flag set.
// Other selects: total read, one multiply, then a fetch/compare pair per halving.
// Reset is synchronous and clears the entry count, the response valid and the controller.
// The receiver cannot stall: each result is shown for exactly one cycle.
module roulette_wheel_select_core #(
   parameter int MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rws_pkg::KIND_W-1:0]    req_kind,
   input  logic [rws_pkg::WEIGHT_W-1:0]  req_cumulative_weight,
   input  logic [rws_pkg::FRAC_W-1:0]    req_random_fraction,
   output logic                          rsp_valid,
   output logic [rws_pkg::INDEX_W-1:0]   rsp_chosen_index,
   output logic                          rsp_empty_error
);

`include "roulette_wheel_select_core_assert.svh"

   rws_pkg::cmd_type    cmd;
   rws_pkg::status_type status;

   // sequencing: accept decode, total fetch, product, search steps
   rws_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // prefix table, bounds, 48-bit scaled draw, result registers
   rws_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_cumulative_weight (req_cumulative_weight),
      .req_random_fraction   (req_random_fraction),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_chosen_index      (rsp_chosen_index),
      .rsp_empty_error       (rsp_empty_error)
   );

   // empty-table select is answered with the error flag set
   `RWS_ASSERT_NEXT(a_empty_select,
      start && !busy && req_kind == rws_pkg::KIND_SELECT && status.count_zero,
      rsp_valid && rsp_empty_error, "empty select did not flag error")

   // a normal result only comes out of a running search
   `RWS_ASSERT_NOW(a_result_from_search, rsp_valid && !rsp_empty_error, $past(busy),
      "search result without a search")

   // at most one bound update or finish per cycle
   `RWS_ASSERT_NOW(a_one_step, 1'b1,
      $onehot0({cmd.go_left, cmd.go_right, cmd.finish_lo, cmd.finish_mid, cmd.finish_err}),
      "conflicting search commands")

endmodule
